FILE: sv/m2a_pkg.sv
// Shared types, constants and the matrix-entry term table of the
// motor-to-affine constant generator. No dependencies.
package m2a_pkg;

  localparam int WORD_W     = 32;
  localparam int NUM_COMP   = 8;
  localparam int COMP_IDX_W = 3;
  localparam int POS_W      = 4;
  localparam int NUM_TERMS  = 4;

  // Output modes
  localparam logic MODE_MATRIX = 1'b0;
  localparam logic MODE_RAW    = 1'b1;

  // Register index on the configuration port
  localparam logic REG_OUTPUT_MODE = 1'b0;

  // Run layout
  localparam logic [POS_W-1:0] MATRIX_LAST_POS  = 4'd15;
  localparam logic [POS_W-1:0] MATRIX_COUNT_POS = 4'd12;
  localparam logic [POS_W-1:0] RAW_LAST_POS     = 4'd11;
  localparam logic [POS_W-1:0] RAW_COUNT_POS    = 4'd8;

  // Component slots in the held motor
  localparam logic [COMP_IDX_W-1:0] C_W  = 3'd0;
  localparam logic [COMP_IDX_W-1:0] C_X  = 3'd1;
  localparam logic [COMP_IDX_W-1:0] C_Y  = 3'd2;
  localparam logic [COMP_IDX_W-1:0] C_Z  = 3'd3;
  localparam logic [COMP_IDX_W-1:0] C_DW = 3'd4;
  localparam logic [COMP_IDX_W-1:0] C_DX = 3'd5;
  localparam logic [COMP_IDX_W-1:0] C_DY = 3'd6;
  localparam logic [COMP_IDX_W-1:0] C_DZ = 3'd7;

  typedef enum logic [1:0] {
    TERM_OFF,
    TERM_ADD,
    TERM_SUB
  } term_op_t;

  typedef struct packed {
    term_op_t                op;
    logic [COMP_IDX_W-1:0]   a;
    logic [COMP_IDX_W-1:0]   b;
  } term_t;

  typedef struct packed {
    term_t [NUM_TERMS-1:0] terms;
    logic                  one;   // add 1.0 (diagonal entries)
  } entry_t;

  // Product terms of matrix entry pos (row-major 3x4), before the factor 2.0
  function automatic entry_t matrix_entry(input logic [POS_W-1:0] pos);
    entry_t e;
    e.one = 1'b0;
    for (int i = 0; i < NUM_TERMS; i++) begin
      e.terms[i] = '{TERM_OFF, C_W, C_W};
    end
    case (pos)
      4'd0: begin
        e.terms[0] = '{TERM_SUB, C_Y, C_Y};
        e.terms[1] = '{TERM_SUB, C_Z, C_Z};
        e.one = 1'b1;
      end
      4'd1: begin
        e.terms[0] = '{TERM_ADD, C_X, C_Y};
        e.terms[1] = '{TERM_SUB, C_Z, C_W};
      end
      4'd2: begin
        e.terms[0] = '{TERM_ADD, C_X, C_Z};
        e.terms[1] = '{TERM_ADD, C_Y, C_W};
      end
      4'd3: begin
        e.terms[0] = '{TERM_SUB, C_DW, C_X};
        e.terms[1] = '{TERM_ADD, C_W, C_DX};
        e.terms[2] = '{TERM_SUB, C_DY, C_Z};
        e.terms[3] = '{TERM_ADD, C_DZ, C_Y};
      end
      4'd4: begin
        e.terms[0] = '{TERM_ADD, C_X, C_Y};
        e.terms[1] = '{TERM_ADD, C_Z, C_W};
      end
      4'd5: begin
        e.terms[0] = '{TERM_SUB, C_X, C_X};
        e.terms[1] = '{TERM_SUB, C_Z, C_Z};
        e.one = 1'b1;
      end
      4'd6: begin
        e.terms[0] = '{TERM_ADD, C_Y, C_Z};
        e.terms[1] = '{TERM_SUB, C_X, C_W};
      end
      4'd7: begin
        e.terms[0] = '{TERM_SUB, C_DW, C_Y};
        e.terms[1] = '{TERM_ADD, C_W, C_DY};
        e.terms[2] = '{TERM_SUB, C_DZ, C_X};
        e.terms[3] = '{TERM_ADD, C_DX, C_Z};
      end
      4'd8: begin
        e.terms[0] = '{TERM_ADD, C_X, C_Z};
        e.terms[1] = '{TERM_SUB, C_Y, C_W};
      end
      4'd9: begin
        e.terms[0] = '{TERM_ADD, C_Y, C_Z};
        e.terms[1] = '{TERM_ADD, C_X, C_W};
      end
      4'd10: begin
        e.terms[0] = '{TERM_SUB, C_X, C_X};
        e.terms[1] = '{TERM_SUB, C_Y, C_Y};
        e.one = 1'b1;
      end
      4'd11: begin
        e.terms[0] = '{TERM_SUB, C_DW, C_Z};
        e.terms[1] = '{TERM_ADD, C_W, C_DZ};
        e.terms[2] = '{TERM_SUB, C_DX, C_Y};
        e.terms[3] = '{TERM_ADD, C_DY, C_X};
      end
      default: ;
    endcase
    return e;
  endfunction

endpackage

FILE: sv/motor_to_affine_constants.sv
// Motor-to-affine constant generator: top level with APB register, motor
// holding stage, multiply stage and round/saturate output stage.
// Depends on m2a_pkg.
//
// One input transaction (a rotation quaternion, a dual quaternion and a point
// count, signed fixed point with FRAC_BITS fraction bits) produces a run of
// 16 output words in matrix mode (3x4 row-major [R | t], count, three zeros)
// or 12 in raw mode (the eight components, count, three zeros), one word per
// cycle while the output is not stalled. Each matrix entry is built from four
// 32x32 multipliers whose products are registered, then summed, doubled,
// rounded half up and saturated to 32 bits in the stage that feeds the output
// register. A motor is captured in the holding stage, then its words pass the
// multiply register and the output register. The next motor is taken in the
// cycle the last word of the current one is issued, so runs follow back to
// back. output_mode is sampled when a motor is accepted.
module motor_to_affine_constants
  import m2a_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [WORD_W-1:0]        pwdata,
  output logic [WORD_W-1:0]        prdata,
  output logic                     pready,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [WORD_W-1:0] rot_w,
  input  logic signed [WORD_W-1:0] rot_x,
  input  logic signed [WORD_W-1:0] rot_y,
  input  logic signed [WORD_W-1:0] rot_z,
  input  logic signed [WORD_W-1:0] dual_w,
  input  logic signed [WORD_W-1:0] dual_x,
  input  logic signed [WORD_W-1:0] dual_y,
  input  logic signed [WORD_W-1:0] dual_z,
  input  logic [WORD_W-1:0]        point_count,
  // output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [WORD_W-1:0]        word,
  output logic [POS_W-1:0]         word_index,
  output logic                     last
);

  localparam int PROD_W = 2 * WORD_W;
  localparam int SUM_W  = PROD_W + 4;

  localparam logic signed [SUM_W-1:0] ONE_Q2 = SUM_W'(1) << (2 * FRAC_BITS);
  localparam logic signed [SUM_W-1:0] HALF_Q = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-WORD_W){1'b0}}, 1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-WORD_W){1'b1}}, 1'b1, {(WORD_W-1){1'b0}}};

  // Configuration register
  logic output_mode;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_OUTPUT_MODE);
  assign prdata    = (paddr[2] == REG_OUTPUT_MODE) ? {{(WORD_W-1){1'b0}}, output_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_mode <= MODE_MATRIX;
    end else if (cfg_write) begin
      output_mode <= pwdata[0];
    end
  end

  // Pipeline advances unless a finished word is stalled at the output
  logic advance;
  assign advance = !out_valid || !out_stall;

  // Holding stage: the motor being expanded and its issue position
  logic signed [WORD_W-1:0] comp [NUM_COMP];
  logic [WORD_W-1:0]        count;
  logic                     mode;
  logic                     busy;
  logic [POS_W-1:0]         pos;
  logic [POS_W-1:0]         last_pos;
  logic                     issue_last;
  logic                     in_take;

  assign last_pos   = (mode == MODE_RAW) ? RAW_LAST_POS : MATRIX_LAST_POS;
  assign issue_last = busy && advance && (pos == last_pos);
  assign in_stall   = busy && !issue_last;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (in_take) begin
      busy <= 1'b1;
      pos  <= '0;
    end else if (busy && advance) begin
      pos <= pos + 1'b1;
      if (pos == last_pos) begin
        busy <= 1'b0;
      end
    end
  end

  // Capture the motor payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      comp[C_W]  <= rot_w;
      comp[C_X]  <= rot_x;
      comp[C_Y]  <= rot_y;
      comp[C_Z]  <= rot_z;
      comp[C_DW] <= dual_w;
      comp[C_DX] <= dual_x;
      comp[C_DY] <= dual_y;
      comp[C_DZ] <= dual_z;
      count      <= point_count;
      mode       <= output_mode;
    end
  end

  // Select operands and the pass-through word for the current position
  entry_t            entry;
  logic              pass;
  logic [WORD_W-1:0] pass_word;

  always_comb begin
    entry     = matrix_entry(pos);
    pass      = 1'b1;
    pass_word = '0;
    if (mode == MODE_RAW) begin
      if (pos < RAW_COUNT_POS) begin
        pass_word = comp[pos[COMP_IDX_W-1:0]];
      end else if (pos == RAW_COUNT_POS) begin
        pass_word = count;
      end
    end else begin
      if (pos < MATRIX_COUNT_POS) begin
        pass = 1'b0;
      end else if (pos == MATRIX_COUNT_POS) begin
        pass_word = count;
      end
    end
  end

  // Multiply stage
  logic                     m_valid;
  logic [POS_W-1:0]         m_pos;
  logic                     m_last;
  logic                     m_pass;
  logic [WORD_W-1:0]        m_pass_word;
  logic                     m_one;
  term_op_t                 m_op   [NUM_TERMS];
  logic signed [PROD_W-1:0] m_prod [NUM_TERMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_pos       <= pos;
      m_last      <= (pos == last_pos);
      m_pass      <= pass;
      m_pass_word <= pass_word;
      m_one       <= entry.one;
      for (int i = 0; i < NUM_TERMS; i++) begin
        m_op[i]   <= entry.terms[i].op;
        m_prod[i] <= comp[entry.terms[i].a] * comp[entry.terms[i].b];
      end
    end
  end

  // Sum, double, add 1.0 on diagonal entries and half an LSB, then floor-shift and saturate
  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] total;
  logic signed [SUM_W-1:0] shifted;
  logic [WORD_W-1:0]       entry_word;

  always_comb begin
    acc = '0;
    for (int i = 0; i < NUM_TERMS; i++) begin
      case (m_op[i])
        TERM_ADD: acc = acc + SUM_W'(m_prod[i]);
        TERM_SUB: acc = acc - SUM_W'(m_prod[i]);
        default:  acc = acc;
      endcase
    end
    total   = (acc <<< 1) + (m_one ? ONE_Q2 : '0) + HALF_Q;
    shifted = total >>> FRAC_BITS;
    if (shifted > SAT_HI) begin
      entry_word = SAT_HI[WORD_W-1:0];
    end else if (shifted < SAT_LO) begin
      entry_word = SAT_LO[WORD_W-1:0];
    end else begin
      entry_word = shifted[WORD_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      word       <= m_pass ? m_pass_word : entry_word;
      word_index <= m_pos;
      last       <= m_last;
    end
  end

endmodule

FILE: sv/m2a_checker.sv
// Port-level checks on the output run of the motor-to-affine constant
// generator, bound to the top level. Depends on m2a_pkg.
module m2a_checker
  import m2a_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [WORD_W-1:0] word,
  input logic [POS_W-1:0]  word_index,
  input logic              last
);

  // Hold a stalled word
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(word) && $stable(word_index))
    else $error("stalled output word changed");

  // Advance the index by one within a run
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=>
      !out_valid || word_index == POS_W'($past(word_index) + 1'b1))
    else $error("word index did not advance by one");

  // Start each new run at index zero
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> !out_valid || word_index == '0)
    else $error("run did not start at index zero");

  // End runs only at the raw or matrix length
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> word_index == RAW_LAST_POS || word_index == MATRIX_LAST_POS)
    else $error("last flag at unexpected index");

  // Drop output valid after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind motor_to_affine_constants m2a_checker u_m2a_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .word       (word),
  .word_index (word_index),
  .last       (last)
);
